### src/fra_pkg.sv
// Shared types and constants for the FIFO resource admission block.
// No dependencies; used by fra_ctrl, fra_dp and fifo_resource_admission.
package fra_pkg;

  localparam int RES_WIDTH   = 12;
  localparam int TIME_WIDTH  = 32;
  localparam int MAX_RESULTS = 16;
  localparam int RPTR_W      = $clog2(MAX_RESULTS);
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] CMD_ARRIVAL  = 2'd0;
  localparam logic [1:0] CMD_COMPLETE = 2'd1;
  localparam logic [1:0] CMD_STATUS   = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  localparam logic [1:0] KIND_ADMIT  = 2'd0;
  localparam logic [1:0] KIND_DROP   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] REG_BUFFER_LIMIT   = 2'd0;
  localparam logic [1:0] REG_TOTAL_CAPACITY = 2'd1;

  typedef struct packed {
    logic [1:0]            command;
    logic [TIME_WIDTH-1:0] now;
    logic                  source_id;
    logic [RES_WIDTH-1:0]  required_resource;
    logic [4:0]            slot;
  } job_in_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [4:0]            granted_slot;
    logic                  job_source;
    logic [RES_WIDTH-1:0]  job_demand;
    logic [TIME_WIDTH-1:0] wait_time;
    logic [RES_WIDTH-1:0]  free_capacity;
    logic [4:0]            queue_count;
    logic [31:0]           penalty_total;
    logic                  last;
  } job_out_t;

  typedef struct packed {
    logic                  src;
    logic [RES_WIDTH-1:0]  dem;
    logic [TIME_WIDTH-1:0] stamp;
  } queue_entry_t;

  typedef struct packed {
    logic                 src;
    logic [RES_WIDTH-1:0] dem;
  } slot_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic enqueue;
    logic push_drop;
    logic push_status;
    logic rel_read;
    logic release_slot;
    logic head_read;
    logic admit;
    logic scan_read;
    logic scan_next;
    logic pen_update;
    logic pen_waiting;
    logic emit_next;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic drop;
    logic fill_zero;
    logic rbuf_full;
    logic admit_ok;
    logic scan_done;
    logic scan_src0;
    logic no_results;
    logic emit_last;
  } dp_stat_t;

endpackage

### src/fifo_resource_admission.sv
// Top level of the FIFO head-of-line resource admission block.
// Depends on fra_pkg, fra_ctrl and fra_dp.
//
//  channel  | handshake               | word
//  item     | item_valid / item_stall | job_in_t: command, now, source, demand, slot
//  result   | result_valid / stall    | job_out_t: one per admission, drop or status
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data (always ready)
//
// One item at a time: status and drop go straight to delivery. A completion first
// releases its slot; an arrival or completion then admits queue heads while they
// fit, scans the queue for the first source 0 job and updates the penalty.
// Results are buffered and delivered one a cycle while result_stall is low, after
// the penalty update for an arrival or completion. Synchronous reset clears all
// control state; queue memory is not cleared. item_stall is high while an accepted
// arrival, completion or status is handled and until all its results are taken.
module fifo_resource_admission #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int ACTIVE_SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  fra_pkg::job_in_t              item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output fra_pkg::job_out_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [fra_pkg::RES_WIDTH-1:0] cfg_data
);
  import fra_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  fra_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_command (item.command),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  fra_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .ACTIVE_SLOTS (ACTIVE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("item accepted while results pending");

  a_single_result_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == KIND_DROP || result.kind == KIND_STATUS)
      |-> result.last)
    else $error("drop or status word not marked last");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last |=> result_valid)
    else $error("result burst ended before last word");

  a_admit_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.admit |-> !cmd.release_slot && !cmd.enqueue)
    else $error("admission overlaps release or enqueue");

endmodule

### src/fra_dp.sv
// Datapath: wait queue memory, active slot table, pool and penalty state,
// result buffer. Depends on fra_pkg; driven by fra_ctrl commands.
module fra_dp #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int ACTIVE_SLOTS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fra_pkg::job_in_t                item,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [fra_pkg::RES_WIDTH-1:0]   cfg_data,
  input  fra_pkg::ctl_cmd_t               cmd,
  output fra_pkg::dp_stat_t               stat,
  output fra_pkg::job_out_t               result
);
  import fra_pkg::*;

  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = $clog2(ACTIVE_SLOTS);
  localparam int CW  = $clog2(ACTIVE_SLOTS + 1);
  localparam int HW  = RES_WIDTH + SW;
  localparam int LW  = (FW > 5) ? FW : 5;
  localparam int SXW = (SW > 5) ? SW : 5;

  logic [4:0]            limit;
  logic [RES_WIDTH-1:0]  free_pool;
  logic [QW-1:0]         head;
  logic [FW-1:0]         fill;
  logic [FW-1:0]         scan_i;
  queue_entry_t          qmem [QUEUE_DEPTH];
  queue_entry_t          qrd;
  slot_entry_t           amem [ACTIVE_SLOTS];
  slot_entry_t           ard;
  logic [ACTIVE_SLOTS-1:0] at_valid;
  logic [HW-1:0]         held;
  logic [CW-1:0]         s1_count;
  logic                  cond_met;
  logic [TIME_WIDTH-1:0] cond_start;
  logic [31:0]           pen;
  job_in_t               cur;
  job_out_t              rbuf [MAX_RESULTS];
  logic [RCNT_W-1:0]     rcount;
  logic [RPTR_W-1:0]     rptr;

  logic [LW-1:0]         limit_eff;
  logic [QW:0]           tail_sum;
  logic [QW-1:0]         tail;
  logic [QW:0]           scan_sum;
  logic [QW-1:0]         scan_addr;
  logic [SXW-1:0]        slot_ext;
  logic                  slot_in_range;
  logic [SW-1:0]         slot_idx;
  logic                  free_any;
  logic [SW-1:0]         free_idx;
  logic [RES_WIDTH:0]    rel_sum;
  logic [HW:0]           avail;
  logic                  cond_now;

  always_comb begin
    limit_eff = (LW'(limit) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : LW'(limit);
    tail_sum  = {1'b0, head} + (QW+1)'(fill);
    tail      = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    scan_sum  = {1'b0, head} + (QW+1)'(scan_i);
    scan_addr = (scan_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                QW'(scan_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(scan_sum);
    slot_ext      = SXW'(cur.slot);
    slot_in_range = ({27'd0, cur.slot} < 32'(ACTIVE_SLOTS));
    slot_idx      = SW'(slot_ext);
    rel_sum   = {1'b0, free_pool} + {1'b0, ard.dem};
    avail     = {1'b0, held} + (HW+1)'(free_pool);
  end

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ACTIVE_SLOTS - 1; i >= 0; i--) begin
      if (!at_valid[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    cond_now = (s1_count != '0) && cmd.pen_waiting && (avail >= (HW+1)'(qrd.dem));
  end

  assign stat.drop       = LW'(fill) >= limit_eff;
  assign stat.fill_zero  = (fill == '0);
  assign stat.rbuf_full  = (rcount == RCNT_W'(MAX_RESULTS));
  assign stat.admit_ok   = free_any && (qrd.dem <= free_pool);
  assign stat.scan_done  = (scan_i == fill);
  assign stat.scan_src0  = !qrd.src;
  assign stat.no_results = (rcount == '0);
  assign stat.emit_last  = (RCNT_W'(rptr) + RCNT_W'(1)) == rcount;

  always_comb begin
    result = rbuf[rptr];
    result.penalty_total = pen;
    result.last = stat.emit_last;
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.enqueue) begin
      qmem[tail] <= '{src: item.source_id, dem: item.required_resource, stamp: item.now};
    end
    if (cmd.head_read) begin
      qrd <= qmem[head];
    end else if (cmd.scan_read) begin
      qrd <= qmem[scan_addr];
    end
    if (cmd.admit && stat.admit_ok) begin
      amem[free_idx] <= '{src: qrd.src, dem: qrd.dem};
    end
    if (cmd.rel_read) begin
      ard <= amem[slot_idx];
    end
  end

  // result buffer and latched item (payload)
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item;
    end
    if (cmd.push_drop || cmd.push_status) begin
      rbuf[0] <= '{kind: cmd.push_drop ? KIND_DROP : KIND_STATUS,
                   granted_slot: 5'd0,
                   job_source: cmd.push_drop ? item.source_id : 1'b0,
                   job_demand: cmd.push_drop ? item.required_resource : '0,
                   wait_time: '0,
                   free_capacity: free_pool,
                   queue_count: 5'(fill),
                   penalty_total: '0,
                   last: 1'b0};
    end else if (cmd.admit && stat.admit_ok) begin
      rbuf[RPTR_W'(rcount)] <= '{kind: KIND_ADMIT,
                                 granted_slot: 5'(free_idx),
                                 job_source: qrd.src,
                                 job_demand: qrd.dem,
                                 wait_time: cur.now - qrd.stamp,
                                 free_capacity: free_pool - qrd.dem,
                                 queue_count: 5'(fill - FW'(1)),
                                 penalty_total: '0,
                                 last: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= 5'd16;
      free_pool  <= RES_WIDTH'(256);
      head       <= '0;
      fill       <= '0;
      scan_i     <= '0;
      at_valid   <= '0;
      held       <= '0;
      s1_count   <= '0;
      cond_met   <= 1'b0;
      cond_start <= '0;
      pen        <= '0;
      rcount     <= '0;
      rptr       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BUFFER_LIMIT:   limit <= cfg_data[4:0];
          REG_TOTAL_CAPACITY: free_pool <= cfg_data;
          default: ;
        endcase
      end
      // drop and status words are pushed in the capture cycle
      if (cmd.capture) begin
        rcount <= (cmd.push_drop || cmd.push_status) ? RCNT_W'(1) : '0;
        rptr   <= '0;
        scan_i <= '0;
      end
      if (cmd.enqueue) begin
        fill <= fill + FW'(1);
      end
      if (cmd.release_slot && slot_in_range && at_valid[slot_idx]) begin
        free_pool <= rel_sum[RES_WIDTH] ? '1 : rel_sum[RES_WIDTH-1:0];
        at_valid[slot_idx] <= 1'b0;
        if (ard.src) begin
          held     <= held - HW'(ard.dem);
          s1_count <= s1_count - CW'(1);
        end
      end
      if (cmd.admit && stat.admit_ok) begin
        head <= (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
        fill <= fill - FW'(1);
        free_pool <= free_pool - qrd.dem;
        at_valid[free_idx] <= 1'b1;
        rcount <= rcount + RCNT_W'(1);
        if (qrd.src) begin
          held     <= held + HW'(qrd.dem);
          s1_count <= s1_count + CW'(1);
        end
      end
      if (cmd.scan_next) begin
        scan_i <= scan_i + FW'(1);
      end
      if (cmd.pen_update) begin
        if (cond_now) begin
          if (!cond_met) begin
            cond_start <= cur.now;
            cond_met   <= 1'b1;
          end
        end else if (cond_met) begin
          pen      <= pen + 32'(cur.now - cond_start);
          cond_met <= 1'b0;
        end
      end
      if (cmd.emit_next) begin
        rptr <= rptr + RPTR_W'(1);
      end
    end
  end

endmodule

### src/fra_ctrl.sv
// Controller: sequences capture, release, admission loop, queue scan,
// penalty update and result delivery. Depends on fra_pkg.
module fra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic [1:0]         item_command,
  output logic               item_stall,
  output logic               result_valid,
  input  logic               result_stall,
  input  fra_pkg::dp_stat_t  stat,
  output fra_pkg::ctl_cmd_t  cmd
);
  import fra_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_REL_RD, S_REL, S_HEAD_RD, S_ADMIT,
    S_SCAN_RD, S_SCAN_CHK, S_PEN, S_EMIT
  } state_t;

  state_t state;
  logic   accept;
  // waiting flag rides with the step that found (or missed) a source 0 job
  logic   pen_waiting;

  assign item_stall   = (state != S_IDLE);
  assign result_valid = (state == S_EMIT);
  assign accept       = item_valid && (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.pen_waiting = pen_waiting;
    unique case (state)
      S_IDLE: begin
        cmd.capture     = accept;
        cmd.enqueue     = accept && (item_command == CMD_ARRIVAL) && !stat.drop;
        cmd.push_drop   = accept && (item_command == CMD_ARRIVAL) && stat.drop;
        cmd.push_status = accept && (item_command == CMD_STATUS);
      end
      // slot number is taken from the captured word
      S_REL_RD:   cmd.rel_read = 1'b1;
      S_REL:      cmd.release_slot = 1'b1;
      S_HEAD_RD:  cmd.head_read = !stat.fill_zero && !stat.rbuf_full;
      S_ADMIT:    cmd.admit = 1'b1;
      S_SCAN_RD:  cmd.scan_read = !stat.scan_done;
      S_SCAN_CHK: cmd.scan_next = !stat.scan_src0;
      S_PEN:      cmd.pen_update = 1'b1;
      S_EMIT:     cmd.emit_next = !result_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pen_waiting <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (item_command)
              CMD_ARRIVAL:  state <= stat.drop ? S_EMIT : S_HEAD_RD;
              CMD_COMPLETE: state <= S_REL_RD;
              CMD_STATUS:   state <= S_EMIT;
              CMD_NONE:     state <= S_IDLE;
              default:      state <= S_IDLE;
            endcase
          end
        end
        S_REL_RD: state <= S_REL;
        S_REL:    state <= S_HEAD_RD;
        S_HEAD_RD: begin
          state <= (stat.fill_zero || stat.rbuf_full) ? S_SCAN_RD : S_ADMIT;
        end
        S_ADMIT:  state <= stat.admit_ok ? S_HEAD_RD : S_SCAN_RD;
        S_SCAN_RD: begin
          if (stat.scan_done) begin
            pen_waiting <= 1'b0;
            state       <= S_PEN;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (stat.scan_src0) begin
            pen_waiting <= 1'b1;
            state       <= S_PEN;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_PEN:  state <= stat.no_results ? S_IDLE : S_EMIT;
        S_EMIT: begin
          if (!result_stall && stat.emit_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
